FILE: hw/rtl/modular_exponentiation_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for modular_exponentiation_top
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle
`define MX_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define MX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Widths and constants shared by the modular exponentiation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package modexp_pkg;

	// Width of the base, exponent, modulus and result fields
	localparam int FIELD_W = 31;

	// Number of exponent bits taken into account
	localparam int EXP_BITS = 31;

	// Exponent bits actually present in the field
	localparam int EXP_W = (EXP_BITS < FIELD_W) ? EXP_BITS : FIELD_W;

	// Step counter of the bit-serial modular multiplier
	localparam int CNT_W = $clog2(FIELD_W);
	localparam logic [CNT_W-1:0] MM_LAST = CNT_W'(FIELD_W - 1);

	// Modulus after reset: one billion plus seven
	localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(1000000007);

	// Smallest modulus that gives a nonzero residue
	localparam logic [FIELD_W-1:0] MODULUS_MIN = FIELD_W'(2);

endpackage

FILE: hw/rtl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Computes base_value ^ exponent mod modulus by right-to-left
// square-and-multiply on one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries base_value and exponent; a
//   request is taken when in_valid is high and in_stall is low. in_stall is
//   high from the accepting edge until the result has been moved into the
//   output register. The output channel (out_valid / out_stall) delivers one
//   power_result per request; the result register holds while out_stall is
//   high, and a new request may be taken while that result still waits.
//   The modulus is written through cfg_valid / cfg_ready / modulus; cfg_ready
//   is high only while the block is idle and no request is offered.
// Sequencing:
//   Each modular product runs on the shared shift-add-reduce unit, one
//   multiplier bit per cycle. A request costs a base reduction, a square
//   per exponent bit up to the highest set bit plus a multiply per set bit,
//   less one square, plus the entry and exit steps; a modulus below two
//   goes straight to the finish.
//   The next request is taken in the cycle after the result is registered.
// Reset:
//   arst_n clears the sequencer and output valid and loads the modulus with
//   one billion plus seven.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [modexp_pkg::FIELD_W-1:0] modulus,
	// Input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [modexp_pkg::FIELD_W-1:0] base_value,
	input  logic [modexp_pkg::FIELD_W-1:0] exponent,
	// Output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [modexp_pkg::FIELD_W-1:0] power_result
);

	localparam int W = modexp_pkg::FIELD_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_BASE = 6'b000010,
		S_EVAL = 6'b000100,
		S_MUL  = 6'b001000,
		S_SQR  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                         state_q;
	logic [W-1:0]                   modulus_q;
	logic [modexp_pkg::EXP_W-1:0]   exp_q;
	logic [W-1:0]                   acc_q;
	logic [W-1:0]                   sq_q;
	logic [W-1:0]                   mm_a_q;
	logic [W-1:0]                   mm_b_q;
	logic [W-1:0]                   mm_r_q;
	logic [modexp_pkg::CNT_W-1:0]   cnt_q;
	logic                           out_valid_q;
	logic [W-1:0]                   out_q;

	logic                           in_accept;
	logic                           mm_last;
	logic                           out_free;
	logic [W+1:0]                   mm_sum;
	logic [W+1:0]                   mm_m1;
	logic [W+1:0]                   mm_m2;
	logic [W-1:0]                   mm_next;

	// Handshake decode
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign mm_last   = (cnt_q == modexp_pkg::MM_LAST);
	assign out_free  = !out_valid_q || !out_stall;

	// Shift-add-reduce step: r = (2r + bit * a) mod m, with r, a < m
	always_comb begin
		mm_sum = {1'b0, mm_r_q, 1'b0} + (mm_b_q[W-1] ? {2'b00, mm_a_q} : '0);
		mm_m1  = {2'b00, modulus_q};
		mm_m2  = {1'b0, modulus_q, 1'b0};
		if (mm_sum >= mm_m2) begin
			mm_next = W'(mm_sum - mm_m2);
		end else if (mm_sum >= mm_m1) begin
			mm_next = W'(mm_sum - mm_m1);
		end else begin
			mm_next = W'(mm_sum);
		end
	end

	// Hold the modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= modexp_pkg::MODULUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= modulus;
		end
	end

	// Sequencer: base reduction, then square and multiply per exponent bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						cnt_q   <= '0;
						state_q <= (modulus_q < modexp_pkg::MODULUS_MIN) ? S_DONE : S_BASE;
					end
				end
				S_BASE, S_MUL, S_SQR: begin
					cnt_q <= cnt_q + 1'b1;
					if (mm_last) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					cnt_q <= '0;
					if (exp_q == '0) begin
						state_q <= S_DONE;
					end else if (exp_q[0]) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: operands, partial residue, accumulator, square
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					exp_q  <= exponent[modexp_pkg::EXP_W-1:0];
					acc_q  <= (modulus_q < modexp_pkg::MODULUS_MIN) ? '0 : W'(1);
					mm_a_q <= W'(1);
					mm_b_q <= base_value;
					mm_r_q <= '0;
				end
			end
			S_BASE: begin
				mm_r_q <= mm_next;
				mm_b_q <= {mm_b_q[W-2:0], 1'b0};
				if (mm_last) begin
					sq_q <= mm_next;
				end
			end
			S_MUL: begin
				mm_r_q <= mm_next;
				mm_b_q <= {mm_b_q[W-2:0], 1'b0};
				if (mm_last) begin
					acc_q    <= mm_next;
					exp_q[0] <= 1'b0;
				end
			end
			S_SQR: begin
				mm_r_q <= mm_next;
				mm_b_q <= {mm_b_q[W-2:0], 1'b0};
				if (mm_last) begin
					sq_q  <= mm_next;
					exp_q <= exp_q >> 1;
				end
			end
			S_EVAL: begin
				mm_r_q <= '0;
				mm_b_q <= sq_q;
				mm_a_q <= exp_q[0] ? acc_q : sq_q;
			end
			default: begin
			end
		endcase
	end

	// Output register: load on finish, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q <= acc_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign power_result = out_q;

	// Checks
	`MX_ASSERT_SAME(a_residue_below_modulus,
		(state_q == S_BASE || state_q == S_MUL || state_q == S_SQR),
		(mm_r_q < modulus_q), "partial residue not below modulus")
	`MX_ASSERT_NEXT(a_valid_from_done, (!out_valid_q || !out_stall),
		(out_valid_q == $past(state_q == S_DONE)), "output valid not tied to finish")
	`MX_ASSERT_NEXT(a_small_modulus_zero,
		(in_accept && modulus_q < modexp_pkg::MODULUS_MIN),
		(state_q == S_DONE && acc_q == '0), "small modulus must give zero")

endmodule
